// ===== design/sm3_pkg.sv =====
// SM3 engine package: block size, initial vector, round constants and helper functions.
// No dependencies.
`default_nettype none
package sm3_pkg;
	localparam int BLOCK_BYTES = 64;
	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [255:0] IV = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_COMP = 6'b000100,
		ST_PAD  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage
`default_nettype wire

// ===== design/sm3_hash_engine.sv =====
// SM3 hash engine top level: byte packing, padding and one-round-per-cycle compression.
// Depends on sm3_pkg.
// A word that fills a block stalls input through the window load (LOAD), the 64 rounds
// (COMP) and the chaining update (FIN); other words are taken without a stall. A last word
// adds one or two pad compressions, then the eight digest words. All rounds use a single
// shared round unit. Reset loads the IV and clears counts; no clearing pass.
`default_nettype none
module sm3_hash_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] msg_word,
	input  wire  [2:0]  byte_count,
	input  wire         last_word,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	localparam int FW = $clog2(sm3_pkg::BLOCK_BYTES);
	localparam int NW = sm3_pkg::BLOCK_BYTES / 4;

	sm3_pkg::state_t state_q;
	logic [31:0] buf_q [NW];
	logic [31:0] win_q [16];
	logic [31:0] cv_q [8];
	logic [31:0] r_q [8];
	logic [FW-1:0] fill_q;
	logic [54:0] total_q;
	logic [5:0] rnd_q;
	logic pad_pend_q, final_q, finish_q;
	logic [63:0] bits_q;
	logic [2:0] oidx_q;

	assign in_stall = (state_q != sm3_pkg::ST_IDLE);
	assign out_valid = (state_q == sm3_pkg::ST_OUT);
	assign digest_word = cv_q[oidx_q];
	assign word_index = oidx_q;
	assign digest_last = (oidx_q == 3'd7);

	// one compression round
	logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wj, wj4, wn, tc;
	always_comb begin
		wj  = win_q[rnd_q[3:0]];
		wj4 = win_q[4'(rnd_q[3:0] + 4'd4)];
		tc  = (rnd_q < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		a12 = sm3_pkg::rotl(r_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + r_q[4] + sm3_pkg::rotl(tc, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ff = r_q[0] ^ r_q[1] ^ r_q[2];
			gg = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
			gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
		tt2 = gg + r_q[7] + ss1 + wj;
		wn = sm3_pkg::perm1(wj ^ win_q[4'(rnd_q[3:0] + 4'd7)]
			^ sm3_pkg::rotl(win_q[4'(rnd_q[3:0] + 4'd13)], 5'd15))
			^ sm3_pkg::rotl(win_q[4'(rnd_q[3:0] + 4'd3)], 5'd7)
			^ win_q[4'(rnd_q[3:0] + 4'd10)];
	end

	// bytes taken from the input word; whether the length fits in this pad block
	logic [2:0] cnt;
	logic [FW:0] fill_sum;
	logic len_fits;
	always_comb begin
		cnt = (!last_word || byte_count > 3'd4) ? 3'd4 : byte_count;
		fill_sum = {1'b0, fill_q} + (FW+1)'(cnt);
		len_fits = !(fill_q > FW'(sm3_pkg::BLOCK_BYTES - 9) && !final_q);
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::ST_IDLE;
			for (int k = 0; k < 8; k++) cv_q[k] <= sm3_pkg::IV[255-32*k -: 32];
			fill_q <= '0;
			total_q <= '0;
			rnd_q <= '0;
			pad_pend_q <= 1'b0;
			final_q <= 1'b0;
			finish_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				sm3_pkg::ST_IDLE: begin
					if (in_valid) begin
						for (int i = 0; i < 4; i++) begin
							if (3'(i) < cnt) begin
								logic [FW-1:0] p;
								p = FW'(fill_q + FW'(i));
								buf_q[p[FW-1:2]][(3-p[1:0])*8 +: 8] <= msg_word[31-8*i -: 8];
							end
						end
						fill_q <= fill_sum[FW-1:0];
						pad_pend_q <= last_word;
						bits_q <= {total_q, 9'd0} + {55'd0, fill_sum[FW-1:0], 3'd0}
							+ (fill_sum[FW] ? 64'd512 : 64'd0);
						if (fill_sum[FW]) begin
							state_q <= sm3_pkg::ST_LOAD;
							rnd_q <= '0;
							final_q <= 1'b0;
						end else if (last_word) begin
							state_q <= sm3_pkg::ST_PAD;
						end
					end
				end
				sm3_pkg::ST_LOAD: begin
					state_q <= sm3_pkg::ST_COMP;
					rnd_q <= '0;
				end
				sm3_pkg::ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= sm3_pkg::ST_FIN;
				end
				sm3_pkg::ST_FIN: begin
					for (int k = 0; k < 8; k++) cv_q[k] <= cv_q[k] ^ r_q[k];
					if (!final_q) total_q <= total_q + 55'd1;
					if (final_q && finish_q) begin
						state_q <= sm3_pkg::ST_OUT;
						oidx_q <= '0;
					end else if (pad_pend_q || final_q) begin
						state_q <= sm3_pkg::ST_PAD;
					end else begin
						state_q <= sm3_pkg::ST_IDLE;
					end
				end
				sm3_pkg::ST_PAD: begin
					// pad byte plus zeros; length only if it fits
					for (int w = 0; w < NW; w++) begin
						for (int b = 0; b < 4; b++) begin
							if ((FW'(4*w+b) > fill_q || (final_q && finish_q == 1'b0))
								&& !(len_fits && w >= NW-2))
								buf_q[w][31-8*b -: 8] <= 8'h00;
						end
					end
					if (!(final_q && !finish_q))
						buf_q[fill_q[FW-1:2]][(3-fill_q[1:0])*8 +: 8] <= sm3_pkg::PAD_BYTE;
					if (!len_fits) begin
						finish_q <= 1'b0;
					end else begin
						buf_q[NW-2] <= bits_q[63:32];
						buf_q[NW-1] <= bits_q[31:0];
						finish_q <= 1'b1;
					end
					final_q <= 1'b1;
					pad_pend_q <= 1'b0;
					state_q <= sm3_pkg::ST_LOAD;
					rnd_q <= '0;
				end
				sm3_pkg::ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= sm3_pkg::ST_IDLE;
							for (int k = 0; k < 8; k++) cv_q[k] <= sm3_pkg::IV[255-32*k -: 32];
							fill_q <= '0;
							total_q <= '0;
							final_q <= 1'b0;
							finish_q <= 1'b0;
						end
					end
				end
				default: state_q <= sm3_pkg::ST_IDLE;
			endcase
		end
	end

	// round registers and schedule window; loaded from block and chaining value outside rounds
	always_ff @(posedge clk) begin
		if (state_q == sm3_pkg::ST_COMP) begin
			r_q[3] <= r_q[2];
			r_q[2] <= sm3_pkg::rotl(r_q[1], 5'd9);
			r_q[1] <= r_q[0];
			r_q[0] <= tt1;
			r_q[7] <= r_q[6];
			r_q[6] <= sm3_pkg::rotl(r_q[5], 5'd19);
			r_q[5] <= r_q[4];
			r_q[4] <= sm3_pkg::perm0(tt2);
			win_q[rnd_q[3:0]] <= wn;
		end else begin
			for (int k = 0; k < 8; k++) r_q[k] <= cv_q[k];
			for (int k = 0; k < 16; k++) win_q[k] <= buf_q[k];
		end
	end
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for sm3_hash_engine: feeds message words, predicts digests.
// Depends on sm3_pkg and sm3_hash_engine.
`default_nettype none
module testbench;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  cnt;
		logic        last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] msg_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_word = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	sm3_hash_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.msg_word(msg_word), .byte_count(byte_count), .last_word(last_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .digest_last(digest_last)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [31:0] hv [8];
	logic [31:0] blk [16];
	int unsigned fill;
	logic [54:0] nblocks;

	msg_item_t    pending_words[$];
	digest_item_t expected_digests[$];
	int errors = 0;
	int msgs_hashed = 0;
	int digests_seen = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit quiet = 1'b0;       // no idling in the final part
	bit long_hold = 1'b0;   // receiver hold-off request
	bit sender_pause = 1'b0;

	function automatic logic [31:0] rl(logic [31:0] x, int n);
		n = n % 32;
		return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
	endfunction

	function automatic logic [31:0] p0f(logic [31:0] x);
		return x ^ rl(x, 9) ^ rl(x, 17);
	endfunction

	function automatic logic [31:0] p1f(logic [31:0] x);
		return x ^ rl(x, 15) ^ rl(x, 23);
	endfunction

	task automatic compress_into_hash();
		logic [31:0] w [16];
		logic [31:0] r [8];
		logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, wj, wn;
		for (int k = 0; k < 16; k++) w[k] = blk[k];
		for (int k = 0; k < 8; k++) r[k] = hv[k];
		for (int j = 0; j < 64; j++) begin
			wj = w[j % 16];
			t = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
			a12 = rl(r[0], 12);
			ss1 = rl(a12 + r[4] + rl(t, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = r[0] ^ r[1] ^ r[2];
				gg = r[4] ^ r[5] ^ r[6];
			end else begin
				ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
				gg = (r[4] & r[5]) | (~r[4] & r[6]);
			end
			tt1 = ff + r[3] + ss2 + (wj ^ w[(j + 4) % 16]);
			tt2 = gg + r[7] + ss1 + wj;
			r[3] = r[2];
			r[2] = rl(r[1], 9);
			r[1] = r[0];
			r[0] = tt1;
			r[7] = r[6];
			r[6] = rl(r[5], 19);
			r[5] = r[4];
			r[4] = p0f(tt2);
			wn = p1f(wj ^ w[(j + 7) % 16] ^ rl(w[(j + 13) % 16], 15))
				^ rl(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
			w[j % 16] = wn;
		end
		for (int k = 0; k < 8; k++) hv[k] ^= r[k];
	endtask

	task automatic store_byte(int unsigned pos, logic [7:0] b);
		int sh;
		sh = (3 - (pos % 4)) * 8;
		blk[pos / 4] = (blk[pos / 4] & ~(32'hFF << sh)) | (32'(b) << sh);
	endtask

	task automatic reset_hash();
		for (int k = 0; k < 8; k++) hv[k] = sm3_pkg::IV[255 - 32 * k -: 32];
		for (int k = 0; k < 16; k++) blk[k] = '0;
		fill = 0;
		nblocks = '0;
	endtask

	// absorb one accepted word; on the last word queue the eight digest words
	task automatic absorb_word(msg_item_t it);
		int unsigned n;
		logic [63:0] bits;
		n = it.cnt;
		if (n > 4 || !it.last) n = 4;
		for (int i = 0; i < n; i++) begin
			store_byte(fill, it.word[31 - 8 * i -: 8]);
			fill++;
			if (fill >= 64) begin
				compress_into_hash();
				nblocks++;
				fill = 0;
			end
		end
		if (it.last) begin
			bits = ({9'b0, nblocks} << 9) + (64'(fill) << 3);
			store_byte(fill, sm3_pkg::PAD_BYTE);
			for (int i = fill + 1; i < 64; i++) store_byte(i, 8'h00);
			if (fill > 55) begin
				compress_into_hash();
				for (int k = 0; k < 16; k++) blk[k] = '0;
			end
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			compress_into_hash();
			for (int i = 0; i < 8; i++)
				expected_digests.push_back('{hv[i], 3'(i), i == 7});
			msgs_hashed++;
			reset_hash();
		end
	endtask

	// sender: offers queued words with random bursts of idle
	int send_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				absorb_word('{msg_word, byte_count, last_word});
				items_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && !sender_pause) begin
					msg_item_t it;
					it = pending_words.pop_front();
					in_valid <= 1'b1;
					msg_word <= it.word;
					byte_count <= it.cnt;
					last_word <= it.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	int stall_left = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (long_hold && hold_left == 0) hold_left <= 400;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: compare each digest word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			digests_seen++;
			if (expected_digests.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d last %b", $time,
					digest_word, word_index, digest_last);
				errors++;
			end else begin
				digest_item_t e;
				e = expected_digests.pop_front();
				if (e.word !== digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time, e.word,
						digest_word);
					errors++;
				end
				if (e.idx !== word_index) begin
					$display("%0t: word_index expected %0d actual %0d", $time, e.idx,
						word_index);
					errors++;
				end
				if (e.last !== digest_last) begin
					$display("%0t: digest_last expected %b actual %b", $time, e.last,
						digest_last);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic add_word(logic [31:0] w, logic [2:0] c, logic l);
		pending_words.push_back('{w, c, l});
	endtask

	// random message: mostly short, a few spanning several blocks
	task automatic add_message(int nwords);
		for (int i = 0; i < nwords - 1; i++)
			add_word($urandom, ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
				1'b0);
		add_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid) @(posedge clk);
		while (expected_digests.size() > 0) @(posedge clk);
	endtask

	initial begin
		reset_hash();
		// directed: empty message, "abc", the pad boundaries, extremes
		add_word(32'h0, 3'd0, 1'b1);
		add_word(32'h61626300, 3'd3, 1'b1);
		for (int i = 0; i < 13; i++) add_word(32'hFFFFFFFF, 3'd4, 1'b0);
		add_word(32'hFFFFFFFF, 3'd4, 1'b1);     // 56 bytes: extra pad block
		add_word(32'h0, 3'd7, 1'b1);            // oversized count, saturates
		add_word(32'hA5A5A5A5, 3'd1, 1'b0);     // short word not last taken as full
		add_word(32'h5A5A5A5A, 3'd2, 1'b1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// boundary lengths around one block
		for (int n = 13; n <= 17; n++) add_message(n);
		add_message(16);
		wait_drained();

		// receiver holds off while the sender keeps going
		long_hold = 1'b1;
		for (int m = 0; m < 6; m++) add_message($urandom_range(1, 6));
		wait (hold_left > 0);
		long_hold = 1'b0;
		wait_drained();

		// random messages
		while (pending_words.size() + items_sent < 400) begin
			if ($urandom_range(0, 9) == 0) add_message($urandom_range(17, 40));
			else add_message($urandom_range(1, 10));
		end
		sender_pause = 1'b1;
		while (expected_digests.size() > 0 || in_valid) @(posedge clk);
		sender_pause = 1'b0;
		wait_drained();

		// final part with no idling
		quiet = 1'b1;
		for (int m = 0; m < 12; m++) add_message($urandom_range(1, 8));
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Sent %0d words in %0d messages, checked %0d digest words",
			items_sent, msgs_hashed, digests_seen);
		if (errors == 0 && expected_digests.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
